>>> rtl/rtdt_pkg.sv
// ----------------------------------------------------------------------------
// rtdt_pkg: shared types and constants of the PT100 converter
// Fixed-point formats of the bisection core, defaults of the top-level
// parameters and the state record handed from one bisection step to the next.
// ----------------------------------------------------------------------------
package rtdt_pkg;

    // Defaults of the top-level parameters.
    localparam int BISECT_STEPS_DEF   = 20;
    localparam int RES_FRAC_BITS_DEF  = 10;
    localparam int TEMP_FRAC_BITS_DEF = 8;

    // Field widths.
    localparam int RES_W  = 19;
    localparam int TEMP_W = 19;

    // Bisection core: estimate in Q20 degC, resistance in Q24 ohm.
    localparam int EST_Q = 20;
    localparam int EST_W = 29;
    localparam int RQ_W  = 40;
    localparam int HM_W  = 24;

    // Stages of each constant divider inside one bisection step.
    localparam int BIS_DIV_LAT = 3;
    localparam int STEP_LAT    = BIS_DIV_LAT + 4;

    // Start of the bisection: t = -100, high = 0, low = -201 (Q20).
    localparam logic signed [EST_W-1:0] EST_START = -29'sd104857600;
    localparam logic signed [EST_W-1:0] EST_HIGH  = 29'sd0;
    localparam logic signed [EST_W-1:0] EST_LOW   = -29'sd210763776;

    // Saturation bounds of the temperature field.
    localparam logic [31:0] TEMP_MAX     = 32'd262143;
    localparam logic [31:0] TEMP_MIN_MAG = 32'd262144;

    // State of one item between bisection steps.
    typedef struct packed {
        logic [RQ_W-1:0]  rq;
        logic [EST_W-1:0] y;
        logic [EST_W-1:0] hi;
        logic [EST_W-1:0] lo;
    } t_bis;

endpackage

>>> rtl/rtdt_div.sv
// ----------------------------------------------------------------------------
// rtdt_div: pipelined dividers
// rtdt_div is a restoring divider for a variable divisor, with the quotient
// bits spread evenly over LAT register stages. rtdt_cdiv divides by a
// constant through a reciprocal multiply and a small correction, in 3 stages.
// ----------------------------------------------------------------------------
module rtdt_div #(
    parameter int NW  = 64,
    parameter int DW  = 33,
    parameter int QW  = 19,
    parameter int LAT = 5
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int BPS = (QW + LAT - 1) / LAT;
    localparam int QT  = BPS * LAT;
    localparam int WW  = DW + QT;

    // Upper DW bits hold the partial remainder, lower QT bits shift the
    // dividend out and the quotient in.
    logic [WW-1:0] r_w [0:LAT-1];
    logic [DW-1:0] r_d [0:LAT-1];

    function automatic logic [WW-1:0] div_steps(input logic [WW-1:0] w,
                                                input logic [DW-1:0] d);
        logic [WW-1:0] acc;
        logic [DW:0]   part;
        logic [DW:0]   diff;
        acc = w;
        for (int b = 0; b < BPS; b++) begin
            part = acc[WW-1:QT-1];
            diff = part - {1'b0, d};
            if (part >= {1'b0, d}) begin
                acc = {diff[DW-1:0], acc[QT-2:0], 1'b1};
            end else begin
                acc = {part[DW-1:0], acc[QT-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

    // Divider stages, advanced together with the rest of the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w[0] <= div_steps(WW'(i_num), i_den);
            r_d[0] <= i_den;
            for (int s = 1; s < LAT; s++) begin
                r_w[s] <= div_steps(r_w[s-1], r_d[s-1]);
                r_d[s] <= r_d[s-1];
            end
        end
    end

    assign o_quo = QW'(r_w[LAT-1][QT-1:0]);

endmodule

// Division by a constant D for a dividend of XW bits (32 to 63). The top 32
// bits of the dividend times floor(2^XW / D) give a quotient at most 2 short;
// the remainder against D and 2D then adds the missing units.
module rtdt_cdiv #(
    parameter int              XW = 40,
    parameter longint unsigned D  = 15625,
    parameter int              QW = 26
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [XW-1:0] i_num,
    output logic [QW-1:0] o_quo
);

    localparam longint unsigned RECIP = (64'd1 << XW) / D;
    localparam int              RW    = $clog2(D) + 3;

    logic [63:0]   prod;
    logic [63:0]   back;
    logic [RW-1:0] rm;
    logic [QW-1:0] n_q;
    logic [XW-1:0] r_x;
    logic [QW-1:0] r_qe;
    logic [RW-1:0] r_rm;
    logic [QW-1:0] r_q1;
    logic [QW-1:0] r_q;

    // Quotient estimate, its remainder and the final correction.
    always_comb begin
        prod = 64'(i_num[XW-1:XW-32]) * RECIP;
        back = 64'(r_qe) * D;
        rm   = RW'(64'(r_x) - back);
        if (r_rm >= RW'(2 * D)) begin
            n_q = r_q1 + QW'(2);
        end else if (r_rm >= RW'(D)) begin
            n_q = r_q1 + QW'(1);
        end else begin
            n_q = r_q1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= i_num;
            r_qe <= QW'(prod >> 32);
            r_rm <= rm;
            r_q1 <= r_qe;
            r_q  <= n_q;
        end
    end

    assign o_quo = r_q;

endmodule

>>> rtl/rtdt_root.sv
// ----------------------------------------------------------------------------
// rtdt_root: quadratic root branch (100 to 390.6 ohm)
// Builds the radicand, takes its floor square root two bits per stage and
// divides with rounding to the temperature in TEMP_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module rtdt_root import rtdt_pkg::*; #(
    parameter int RES_FRAC_BITS  = RES_FRAC_BITS_DEF,
    parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [RES_W-1:0]            i_rf,
    output logic [TEMP_FRAC_BITS+10:0]  o_quo
);

    localparam int QDW    = TEMP_FRAC_BITS + 11;
    localparam int DLAT   = (QDW + 3) / 4;
    localparam int SQ_ST  = 16;
    localparam int NUM_SH = TEMP_FRAC_BITS + 16 - RES_FRAC_BITS;
    localparam int RAD_SH = 32 - RES_FRAC_BITS;
    localparam logic [63:0] RES_100 = 64'd100 << RES_FRAC_BITS;
    localparam logic [63:0] RAD0    = 64'd1527480889 << 32;
    localparam logic [32:0] DEN0    = 33'd2561343488;

    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] q;
    } t_sq;

    logic [RES_W-1:0] dr;
    logic [63:0]      rad;
    logic [63:0]      num;
    logic [63:0]      r_rad;
    logic [63:0]      r_num;
    t_sq              r_sq  [0:SQ_ST-1];
    logic [63:0]      r_sqn [0:SQ_ST-1];
    logic [32:0]      den;
    logic [32:0]      r_den;
    logic [63:0]      r_nn;

    // Two digits of the square root recurrence.
    function automatic t_sq sq_steps(input t_sq s);
        t_sq         a;
        logic [34:0] rem2;
        logic [34:0] trial;
        a = s;
        for (int b = 0; b < 2; b++) begin
            rem2  = {a.rem[32:0], a.rad[63:62]};
            trial = {1'b0, a.q, 2'b01};
            if (rem2 >= trial) begin
                a.rem = rem2 - trial;
                a.q   = {a.q[30:0], 1'b1};
            end else begin
                a.rem = rem2;
                a.q   = {a.q[30:0], 1'b0};
            end
            a.rad = {a.rad[61:0], 2'b00};
        end
        return a;
    endfunction

    // Radicand and numerator from the offset above 100 ohm.
    always_comb begin
        dr  = i_rf - RES_W'(RES_100);
        rad = RAD0 - ((64'(dr) * 64'd2310000) << RAD_SH);
        num = (64'(dr) * 64'd200000) << NUM_SH;
    end

    assign den = DEN0 + 33'(r_sq[SQ_ST-1].q);

    // Radicand register, root stages and the rounded dividend.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad    <= rad;
            r_num    <= num;
            r_sq[0]  <= sq_steps('{rad: r_rad, rem: 35'd0, q: 32'd0});
            r_sqn[0] <= r_num;
            for (int s = 1; s < SQ_ST; s++) begin
                r_sq[s]  <= sq_steps(r_sq[s-1]);
                r_sqn[s] <= r_sqn[s-1];
            end
            r_den <= den;
            r_nn  <= r_sqn[SQ_ST-1] + 64'(den >> 1);
        end
    end

    rtdt_div #(
        .NW  (64),
        .DW  (33),
        .QW  (QDW),
        .LAT (DLAT)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_nn),
        .i_den (r_den),
        .o_quo (o_quo)
    );

endmodule

>>> rtl/rtdt_bisect_step.sv
// ----------------------------------------------------------------------------
// rtdt_bisect_step: one bisection step on the quartic CVD form
// Evaluates r(t) in Q24 ohm at the current estimate, compares it with the
// measured resistance and halves the interval.
// ----------------------------------------------------------------------------
module rtdt_bisect_step import rtdt_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_bis i_st,
    output t_bis o_st
);

    localparam int NC = 3 + BIS_DIV_LAT;
    localparam logic [41:0] CVD_R0 = 42'd1677721600;

    logic [EST_W-1:0] ym;
    logic [HM_W-1:0]  hm;
    logic [HM_W:0]    gm;

    t_bis             r_st [0:NC-1];
    logic [HM_W-1:0]  r_hm [0:NC-1];
    logic [47:0]      r_hh;
    logic [48:0]      r_hg;
    logic [31:0]      r_l1;
    logic [47:0]      r_p;
    logic [60:0]      r_sqx;
    logic [31:0]      r_l1b;
    logic [60:0]      r_qx;
    logic [60:0]      r_sqx2;
    logic [31:0]      r_l1c;

    logic [19:0]      linq;
    logic [25:0]      sq;
    logic [24:0]      quart;
    logic [41:0]      sub;
    logic signed [41:0] rhs;
    logic             above;
    logic signed [EST_W:0] s_sum;
    logic signed [EST_W:0] s_half;
    t_bis             cur;
    t_bis             n_st;
    t_bis             r_out;

    // Magnitude of the estimate truncated to Q16, and t - 100.
    always_comb begin
        ym = EST_W'(-$signed(i_st.y));
        hm = ym[HM_W+3:4];
        gm = {1'b0, hm} + 25'd6553600;
    end

    // Product stages, then the carried state through the divider stages.
    // The square term uses 5775 / 25600000000 = 231 / (2^16 * 15625).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= i_st;
            r_hm[0] <= hm;
            for (int s = 1; s < NC; s++) begin
                r_st[s] <= r_st[s-1];
                r_hm[s] <= r_hm[s-1];
            end
            r_hh   <= 48'(hm) * 48'(hm);
            r_hg   <= 49'(hm) * 49'(gm);
            r_l1   <= 32'(hm) * 32'd164;
            r_p    <= 48'(r_hg[47:24]) * 48'(r_hh[47:24]);
            r_sqx  <= 61'(r_hh) * 61'd231;
            r_l1b  <= r_l1;
            r_qx   <= 61'(r_p) * 61'd4183;
            r_sqx2 <= r_sqx;
            r_l1c  <= r_l1b;
            r_out  <= n_st;
        end
    end

    // Fractional part of the linear term.
    rtdt_cdiv #(.XW(32), .D(3125), .QW(20)) u_lin (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_l1c),
        .o_quo (linq)
    );

    // Square term.
    rtdt_cdiv #(.XW(40), .D(15625), .QW(26)) u_sq (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (40'(r_sqx2 >> 16)),
        .o_quo (sq)
    );

    // Quartic term: 39062500000 is 2^5 times 1220703125.
    rtdt_cdiv #(.XW(55), .D(1220703125), .QW(25)) u_quart (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (55'(r_qx >> 5)),
        .o_quo (quart)
    );

    // Compare with r(t) and move one end of the interval.
    always_comb begin
        cur   = r_st[NC-1];
        sub   = 42'(r_hm[NC-1]) * 42'd100 + 42'(linq) + 42'(sq) + 42'(quart);
        rhs   = $signed(CVD_R0) - $signed(sub);
        above = $signed({2'b00, cur.rq}) > rhs;
        n_st  = cur;
        if (above) begin
            n_st.lo = cur.y;
            s_sum   = $signed({cur.hi[EST_W-1], cur.hi}) + $signed({cur.y[EST_W-1], cur.y});
        end else begin
            n_st.hi = cur.y;
            s_sum   = $signed({cur.y[EST_W-1], cur.y}) + $signed({cur.lo[EST_W-1], cur.lo});
        end
        // Halve with truncation toward zero.
        s_half = (s_sum + $signed({{EST_W{1'b0}}, s_sum[EST_W]})) >>> 1;
        n_st.y = EST_W'(s_half);
    end

    assign o_st = r_out;

endmodule

>>> rtl/rtd_resistance_to_temperature_top.sv
// ----------------------------------------------------------------------------
// rtd_resistance_to_temperature_top: PT100 resistance to temperature
// Inverse Callendar-Van Dusen: closed-form root above 100 ohm, bisection
// below 100 ohm, fault flag outside 39.5 to 390.6 ohm.
// ----------------------------------------------------------------------------
// The block accepts one resistance item in every cycle unless a finished item
// waits at the output, and returns one temperature item per resistance, in
// order. The bisection sets the depth of the pipeline: each step is a 7-stage
// section whose three constant dividers take 3 of those stages. The root
// branch is shorter and is delayed to line up with the bisection. A stall on
// the output holds the whole pipeline.
module rtd_resistance_to_temperature_top import rtdt_pkg::*; #(
    parameter int BISECT_STEPS   = BISECT_STEPS_DEF,
    parameter int RES_FRAC_BITS  = RES_FRAC_BITS_DEF,
    parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RES_W-1:0]  i_resistance,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [TEMP_W-1:0] o_temperature,
    output logic              o_sensor_fault
);

    localparam int QDW      = TEMP_FRAC_BITS + 11;
    localparam int RDLAT    = (QDW + 3) / 4;
    localparam int ROOT_LAT = 18 + RDLAT;
    localparam int BIS_LAT  = BISECT_STEPS * STEP_LAT;
    localparam int PAD      = BIS_LAT - ROOT_LAT;
    localparam int RND_SH   = EST_Q - TEMP_FRAC_BITS;
    localparam logic [31:0] LIM_LOW  = 32'(64'd79 << (RES_FRAC_BITS - 1));
    localparam logic [31:0] LIM_HIGH = 32'(64'd3906 << RES_FRAC_BITS);
    localparam logic [31:0] LIM_MID  = 32'(64'd100 << RES_FRAC_BITS);
    localparam logic [EST_W-1:0] RND = EST_W'(64'd1 << (RND_SH - 1));

    logic             en;
    logic             r_in_vld;
    logic [RES_W-1:0] r_rf;
    logic             fault;
    logic             upper;
    logic             r_vld [0:BIS_LAT-1];
    logic             r_flt [0:BIS_LAT-1];
    logic             r_upr [0:BIS_LAT-1];
    logic [QDW-1:0]   root_q;
    logic [QDW-1:0]   r_rdl [0:PAD-1];
    t_bis             s_chain [0:BISECT_STEPS];
    logic [EST_W-1:0] ym;
    logic [EST_W-1:0] mr;
    logic [TEMP_W-1:0] n_temp;
    logic             r_out_vld;
    logic [TEMP_W-1:0] r_temp;
    logic             r_fault;

    // The whole pipeline moves unless a finished item waits at the output.
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en && i_rst_n;

    // Range check and branch choice on the registered resistance.
    always_comb begin
        fault = (32'(r_rf) < LIM_LOW) || (32'(r_rf) * 32'd10 > LIM_HIGH);
        upper = 32'(r_rf) >= LIM_MID;
    end

    // Start of the bisection.
    always_comb begin
        s_chain[0].rq = RQ_W'(r_rf) << (24 - RES_FRAC_BITS);
        s_chain[0].y  = EST_START;
        s_chain[0].hi = EST_HIGH;
        s_chain[0].lo = EST_LOW;
    end

    generate
        for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_step
            rtdt_bisect_step u_step (
                .i_clk (i_clk),
                .i_en  (en),
                .i_st  (s_chain[k]),
                .o_st  (s_chain[k+1])
            );
        end
    endgenerate

    rtdt_root #(
        .RES_FRAC_BITS  (RES_FRAC_BITS),
        .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
    ) u_root (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rf  (r_rf),
        .o_quo (root_q)
    );

    // Valid bits of the input register, the pipeline and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int s = 0; s < BIS_LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_in_vld  <= i_valid;
            r_vld[0]  <= r_in_vld;
            for (int s = 1; s < BIS_LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_vld <= r_vld[BIS_LAT-1];
        end
    end

    // Input register, flag line, root delay line and output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rf     <= i_resistance;
            r_flt[0] <= fault;
            r_upr[0] <= upper;
            for (int s = 1; s < BIS_LAT; s++) begin
                r_flt[s] <= r_flt[s-1];
                r_upr[s] <= r_upr[s-1];
            end
            r_rdl[0] <= root_q;
            for (int s = 1; s < PAD; s++) begin
                r_rdl[s] <= r_rdl[s-1];
            end
            r_temp  <= n_temp;
            r_fault <= r_flt[BIS_LAT-1];
        end
    end

    // Round the bisection result, saturate and pick the branch.
    always_comb begin
        ym = EST_W'(-$signed(s_chain[BISECT_STEPS].y));
        mr = (ym + RND) >> RND_SH;
        if (r_flt[BIS_LAT-1]) begin
            n_temp = '0;
        end else if (r_upr[BIS_LAT-1]) begin
            if (32'(r_rdl[PAD-1]) > TEMP_MAX) begin
                n_temp = TEMP_W'(TEMP_MAX);
            end else begin
                n_temp = TEMP_W'(r_rdl[PAD-1]);
            end
        end else begin
            if (32'(mr) > TEMP_MIN_MAG) begin
                n_temp = TEMP_W'(-$signed({1'b0, TEMP_MIN_MAG}));
            end else begin
                n_temp = TEMP_W'(-$signed({1'b0, mr}));
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_temperature  = r_temp;
    assign o_sensor_fault = r_fault;

endmodule

>>> rtl/rtdt_checker.sv
// ----------------------------------------------------------------------------
// rtdt_checker: port-level checks of the PT100 converter
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
module rtdt_checker import rtdt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic [RES_W-1:0]  i_resistance,
    input logic              o_valid,
    input logic              i_ready,
    input logic [TEMP_W-1:0] o_temperature,
    input logic              o_sensor_fault
);

    // A faulted item always reads zero degrees.
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sensor_fault |-> o_temperature == '0)
        else $error("faulted item with nonzero temperature");

    // A waiting result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_temperature)
                                && $stable(o_sensor_fault))
        else $error("result item changed while stalled");

    // A stalled output blocks new items.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while output stalled");

    // An empty output stage never holds off the input.
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input held off with empty output stage");

endmodule

bind rtd_resistance_to_temperature_top rtdt_checker u_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the PT100 resistance to temperature converter
// Sends resistance items through a valid/ready channel, computes each expected
// temperature and fault flag with an integer model of the inverse
// Callendar-Van Dusen conversion, and checks each returned item in order.
// ----------------------------------------------------------------------------
module tb_top;
    import rtdt_pkg::*;

    localparam int  RFB          = RES_FRAC_BITS_DEF;
    localparam int  TFB          = TEMP_FRAC_BITS_DEF;
    localparam int  STEPS        = BISECT_STEPS_DEF;
    localparam int  PIPE_LAT     = 2 + STEP_LAT * STEPS;
    localparam int  CYCLE_LIMIT  = 400000;
    // Range edges in resistance units.
    localparam int  R_LOW_EDGE   = 79 << (RFB - 1);
    localparam int  R_MID_EDGE   = 100 << RFB;
    localparam int  R_HIGH_EDGE  = (3906 << RFB) / 10;

    typedef struct {
        logic signed [TEMP_W-1:0] temperature;
        logic                     fault;
    } t_temp_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [RES_W-1:0]  i_resistance = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [TEMP_W-1:0] o_temperature;
    logic              o_sensor_fault;

    t_temp_item temp_queue[$];
    int         errors = 0;
    int         cycles = 0;
    bit         no_idle = 1'b0;

    rtd_resistance_to_temperature_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_resistance  (i_resistance),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_temperature (o_temperature),
        .o_sensor_fault(o_sensor_fault)
    );

    always #2 i_clk = ~i_clk;

    // Floor square root of a 64-bit value, bit by bit.
    function automatic longint unsigned isqrt64(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Sensor resistance in Q24 ohm for a Q20 degC estimate below zero.
    function automatic longint pt100_ohms_q24(input longint est);
        longint h, g, lin, sq, p8, q8, quart;
        h = est / 16;
        g = h - 64'sd100 * 65536;
        lin = 64'sd39083 * h * 256 / 100000;
        sq = 64'sd5775 * h * h / 64'sd25600000000;
        p8 = h * g / 16777216;
        q8 = h * h / 16777216;
        quart = 64'sd4183 * p8 * q8 / 64'sd39062500000;
        return (64'sd100 <<< 24) + lin - sq - quart;
    endfunction

    // Expected temperature and fault flag for one resistance.
    function automatic t_temp_item predict_temperature(input logic [RES_W-1:0] res);
        t_temp_item      exp_item;
        longint          t, hi, lo, y, rq;
        longint unsigned rf, dr, rad, den, num, m;
        rf = res;
        t = 0;
        exp_item.fault = 1'b0;
        if (rf < R_LOW_EDGE || rf * 10 > (64'd3906 << RFB)) begin
            exp_item.fault = 1'b1;
        end else if (rf >= R_MID_EDGE) begin
            // Closed-form root, written to avoid cancellation.
            dr = rf - R_MID_EDGE;
            rad = (64'd39083 * 39083) << 32;
            rad = rad - ((64'd2310000 * dr) << (32 - RFB));
            den = (64'd39083 << 16) + isqrt64(rad);
            num = (dr * 200000) << (TFB + 16 - RFB);
            t = longint'((num + den / 2) / den);
        end else begin
            // Fixed-length bisection between -201 and 0 degC.
            hi = 0;
            lo = -201 * (64'sd1 <<< EST_Q);
            y = -100 * (64'sd1 <<< EST_Q);
            rq = longint'(rf << (24 - RFB));
            for (int k = 0; k < STEPS; k++) begin
                if (rq > pt100_ohms_q24(y)) begin
                    lo = y;
                    y = (hi + y) / 2;
                end else begin
                    hi = y;
                    y = (y + lo) / 2;
                end
            end
            m = longint'(-y);
            m = (m + (64'd1 << (EST_Q - TFB - 1))) >> (EST_Q - TFB);
            t = -longint'(m);
        end
        if (t > 262143) t = 262143;
        if (t < -262144) t = -262144;
        exp_item.temperature = t[TEMP_W-1:0];
        return exp_item;
    endfunction

    // Result side: random stalls, except during the stall-free stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 14);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_temp_item exp_item;
        if (i_rst_n && o_valid && i_ready) begin
            if (temp_queue.size() == 0) begin
                $display("%0t: unexpected item temperature=%0d fault=%0b", $time,
                         $signed(o_temperature), o_sensor_fault);
                errors++;
            end else begin
                exp_item = temp_queue.pop_front();
                if (o_temperature !== exp_item.temperature) begin
                    $display("%0t: temperature expected %0d actual %0d", $time,
                             exp_item.temperature, $signed(o_temperature));
                    errors++;
                end
                if (o_sensor_fault !== exp_item.fault) begin
                    $display("%0t: sensor_fault expected %0b actual %0b", $time,
                             exp_item.fault, o_sensor_fault);
                    errors++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one resistance item, with a random gap in front unless idling is off.
    task automatic send_resistance(input logic [RES_W-1:0] res);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 14) gap = $urandom_range(4, 1);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_resistance <= res;
        do @(posedge i_clk); while (!o_ready);
        temp_queue.push_back(predict_temperature(res));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (temp_queue.size() != 0) @(posedge i_clk);
    endtask

    // Random resistance: mostly in range, sometimes anywhere in the field.
    function automatic logic [RES_W-1:0] random_resistance();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return RES_W'($urandom_range(R_HIGH_EDGE, R_MID_EDGE));
        if (sel < 80) return RES_W'($urandom_range(R_MID_EDGE - 1, R_LOW_EDGE));
        if (sel < 88) return RES_W'($urandom_range(R_LOW_EDGE + 8, R_LOW_EDGE - 8));
        return RES_W'($urandom_range((1 << RES_W) - 1, 0));
    endfunction

    // Field extremes and the branch boundaries.
    task automatic test_boundaries();
        int pts[$];
        pts = '{0, 1, R_LOW_EDGE - 1, R_LOW_EDGE, R_LOW_EDGE + 1, 60000,
                R_MID_EDGE - 1, R_MID_EDGE, R_MID_EDGE + 1, 200000, 300000,
                R_HIGH_EDGE - 1, R_HIGH_EDGE, R_HIGH_EDGE + 1, 262144, 349525,
                174762, (1 << RES_W) - 1};
        foreach (pts[i]) send_resistance(RES_W'(pts[i]));
    endtask

    task automatic test_random(input int count);
        repeat (count) send_resistance(random_resistance());
    endtask

    // Hold the sender until every expected result has come back.
    task automatic test_drain_pause();
        test_random(40);
        wait_drained();
        test_random(40);
    endtask

    // Back-to-back items on both sides.
    task automatic test_no_idle();
        no_idle = 1'b1;
        test_random(250);
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_boundaries();
        test_random(180);
        test_drain_pause();
        test_no_idle();
        test_random(180);
        wait_drained();
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rtdt_pkg.sv
rtl/rtdt_div.sv
rtl/rtdt_root.sv
rtl/rtdt_bisect_step.sv
rtl/rtd_resistance_to_temperature_top.sv
rtl/rtdt_checker.sv
sim/tb_top.sv
